// ----- rtl/sample_min_max_mean_variance_unit_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the sample statistics unit
// Concurrent checks that can be removed by defining NO_ASSERTIONS.
// ----------------------------------------------------------------------------
`ifndef SAMPLE_MIN_MAX_MEAN_VARIANCE_UNIT_ASSERT_SVH
`define SAMPLE_MIN_MAX_MEAN_VARIANCE_UNIT_ASSERT_SVH

`ifndef NO_ASSERTIONS

// General property check on a clock with an active-low reset.
`define SMMV_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition that must never hold while out of reset.
`define SMMV_NEVER(label, clk, rst_n, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`else

`define SMMV_ASSERT(label, clk, rst_n, prop, msg)
`define SMMV_NEVER(label, clk, rst_n, cond, msg)

`endif

`endif

// ----- rtl/smmv_pkg.sv -----
// ----------------------------------------------------------------------------
// Sample statistics package
// Sizes, request and result types shared by the sample statistics unit.
// ----------------------------------------------------------------------------
`default_nettype none

package smmv_pkg;

	// Field widths fixed by the interface.
	localparam int SAMPLE_W   = 16;
	localparam int MEAN_W     = 32;
	localparam int VAR_W      = 46;
	localparam int SET_SIZE_W = 11;

	// Set capacity and fixed-point format.
	localparam int MAX_COUNT = 1024;
	localparam int FRAC_BITS = 16;

	// Accumulator widths that follow from the capacity.
	localparam int CNT_W   = $clog2(MAX_COUNT + 1);
	localparam int SUM_W   = SAMPLE_W + CNT_W;
	localparam int MAG_W   = SUM_W - 1;
	localparam int SQ_W    = 2 * SAMPLE_W - 2 + CNT_W;
	localparam int SQ_LO_W = (SQ_W + 1) / 2;

	// Shared multiplier and divider widths.
	localparam int MUL_W  = MAG_W;
	localparam int PROD_W = 2 * MUL_W;
	localparam int D_W    = CNT_W + SQ_W;
	localparam int DVS_W  = 2 * CNT_W;
	localparam int DVD_W  = D_W + FRAC_BITS;
	localparam int STEP_W = $clog2(DVD_W);

	// One input request.
	typedef struct packed {
		logic signed [SAMPLE_W-1:0] sample;
		logic                       last_item;
	} item_t;

	// One result.
	typedef struct packed {
		logic signed [SAMPLE_W-1:0] max_value;
		logic signed [SAMPLE_W-1:0] min_value;
		logic signed [MEAN_W-1:0]   mean_fixed;
		logic [VAR_W-1:0]           variance_fixed;
		logic [SET_SIZE_W-1:0]      set_size;
		logic                       too_many;
	} result_t;

endpackage

`default_nettype wire

// ----- rtl/sample_min_max_mean_variance_unit.sv -----
// Throughput: a sample without the last mark is taken every cycle, result-free.
// A last sample closes the set: item_ready stays low while one shared multiplier
// forms the products and one restoring divider, one quotient bit per cycle, runs
// mean then variance, and also while an earlier result waits; the result register
// loads at the end.
// Reset (arst_n low) clears the open set, the sequencer and the output valid.
// ----------------------------------------------------------------------------
// Sample statistics unit
// Running minimum, maximum, mean and population variance of a sample set.
// ----------------------------------------------------------------------------
`default_nettype none

`include "sample_min_max_mean_variance_unit_assert.svh"

module sample_min_max_mean_variance_unit (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             item_valid,
	output logic                  item_ready,
	input  wire smmv_pkg::item_t  item,
	output logic                  result_valid,
	input  wire logic             result_ready,
	output smmv_pkg::result_t     result
);

	typedef enum logic [3:0] {
		ST_ACC,
		ST_MUL_SQ,
		ST_MUL_LO,
		ST_MUL_HI,
		ST_MUL_N2,
		ST_DIV_MEAN,
		ST_MEAN_END,
		ST_DIV_VAR,
		ST_FINISH
	} state_t;

	localparam logic [smmv_pkg::DVD_W-1:0] MEAN_POS_MAX =
		smmv_pkg::DVD_W'((64'd1 << (smmv_pkg::MEAN_W - 1)) - 64'd1);
	localparam logic [smmv_pkg::DVD_W-1:0] MEAN_NEG_LIM =
		smmv_pkg::DVD_W'(64'd1 << (smmv_pkg::MEAN_W - 1));
	localparam logic [smmv_pkg::DVD_W-1:0] VAR_MAX =
		smmv_pkg::DVD_W'((64'd1 << smmv_pkg::VAR_W) - 64'd1);
	localparam logic [smmv_pkg::CNT_W-1:0] COUNT_FULL =
		smmv_pkg::CNT_W'(smmv_pkg::MAX_COUNT);
	localparam logic [smmv_pkg::STEP_W-1:0] STEP_LAST =
		smmv_pkg::STEP_W'(smmv_pkg::DVD_W - 1);

	state_t                              state_q;
	logic [smmv_pkg::CNT_W-1:0]          count_q;
	logic signed [smmv_pkg::SUM_W-1:0]   sum_q;
	logic [smmv_pkg::SQ_W-1:0]           sumsq_q;
	logic signed [smmv_pkg::SAMPLE_W-1:0] min_q;
	logic signed [smmv_pkg::SAMPLE_W-1:0] max_q;
	logic                                ovf_q;

	logic [smmv_pkg::PROD_W-1:0]         sq_q;
	logic [smmv_pkg::D_W-1:0]            acc_q;
	logic [smmv_pkg::DVD_W-1:0]          dvd_q;
	logic [smmv_pkg::DVS_W-1:0]          divisor_q;
	logic [smmv_pkg::DVS_W-1:0]          rem_q;
	logic [smmv_pkg::STEP_W-1:0]         step_q;
	logic signed [smmv_pkg::MEAN_W-1:0]  mean_q;
	logic                                result_valid_q;
	smmv_pkg::result_t                   result_q;

	logic [smmv_pkg::SAMPLE_W-1:0]       samp_mag;
	logic [smmv_pkg::MAG_W-1:0]          sum_mag;
	logic [smmv_pkg::MUL_W-1:0]          mul_a;
	logic [smmv_pkg::MUL_W-1:0]          mul_b;
	logic [smmv_pkg::PROD_W-1:0]         prod;
	logic [smmv_pkg::DVS_W:0]            rem_sh;
	logic                                div_ge;
	logic [smmv_pkg::DVS_W-1:0]          rem_nx;
	logic [smmv_pkg::DVD_W-1:0]          dvd_nx;
	logic [smmv_pkg::D_W-1:0]            diff;
	logic [smmv_pkg::MEAN_W-1:0]         mean_mag;
	logic signed [smmv_pkg::MEAN_W-1:0]  mean_nx;
	logic [smmv_pkg::VAR_W-1:0]          var_nx;
	logic                                take;
	logic                                out_free;

	// Handshake decode.
	assign item_ready   = (state_q == ST_ACC);
	assign take         = item_valid && item_ready;
	assign out_free     = !result_valid_q || result_ready;
	assign result_valid = result_valid_q;
	assign result       = result_q;

	// Magnitudes of the incoming sample and of the running sum.
	assign samp_mag = item.sample[smmv_pkg::SAMPLE_W-1] ?
		$unsigned(-item.sample) : $unsigned(item.sample);
	assign sum_mag = sum_q[smmv_pkg::SUM_W-1] ?
		smmv_pkg::MAG_W'($unsigned(-sum_q)) : smmv_pkg::MAG_W'($unsigned(sum_q));

	// Operand selection for the shared multiplier.
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (state_q)
			ST_ACC: begin
				mul_a = smmv_pkg::MUL_W'(samp_mag);
				mul_b = smmv_pkg::MUL_W'(samp_mag);
			end
			ST_MUL_SQ: begin
				mul_a = sum_mag;
				mul_b = sum_mag;
			end
			ST_MUL_LO: begin
				mul_a = smmv_pkg::MUL_W'(count_q);
				mul_b = smmv_pkg::MUL_W'(sumsq_q[smmv_pkg::SQ_LO_W-1:0]);
			end
			ST_MUL_HI: begin
				mul_a = smmv_pkg::MUL_W'(count_q);
				mul_b = smmv_pkg::MUL_W'(sumsq_q[smmv_pkg::SQ_W-1:smmv_pkg::SQ_LO_W]);
			end
			ST_MUL_N2: begin
				mul_a = smmv_pkg::MUL_W'(count_q);
				mul_b = smmv_pkg::MUL_W'(count_q);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign prod = smmv_pkg::PROD_W'(mul_a) * smmv_pkg::PROD_W'(mul_b);

	// One restoring division step: one quotient bit per cycle.
	assign rem_sh = {rem_q, dvd_q[smmv_pkg::DVD_W-1]};
	assign div_ge = (rem_sh >= {1'b0, divisor_q});
	assign rem_nx = div_ge ? smmv_pkg::DVS_W'(rem_sh - {1'b0, divisor_q})
		: smmv_pkg::DVS_W'(rem_sh);
	assign dvd_nx = {dvd_q[smmv_pkg::DVD_W-2:0], div_ge};

	// Variance numerator n*sumsq - sum^2, never negative.
	assign diff = acc_q - smmv_pkg::D_W'(sq_q);

	// Mean from the finished quotient, with sign and saturation.
	always_comb begin
		if (sum_q[smmv_pkg::SUM_W-1]) begin
			mean_mag = (dvd_q > MEAN_NEG_LIM) ? smmv_pkg::MEAN_W'(MEAN_NEG_LIM)
				: dvd_q[smmv_pkg::MEAN_W-1:0];
			mean_nx  = $signed(-mean_mag);
		end else begin
			mean_mag = (dvd_q > MEAN_POS_MAX) ? smmv_pkg::MEAN_W'(MEAN_POS_MAX)
				: dvd_q[smmv_pkg::MEAN_W-1:0];
			mean_nx  = $signed(mean_mag);
		end
	end

	// Variance from the finished quotient, saturated to the field.
	assign var_nx = (dvd_q > VAR_MAX) ? smmv_pkg::VAR_W'(VAR_MAX)
		: dvd_q[smmv_pkg::VAR_W-1:0];

	// Sequencer, accumulators, shared-unit registers and result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_ACC;
			count_q        <= '0;
			sum_q          <= '0;
			sumsq_q        <= '0;
			min_q          <= '0;
			max_q          <= '0;
			ovf_q          <= 1'b0;
			sq_q           <= '0;
			acc_q          <= '0;
			dvd_q          <= '0;
			divisor_q      <= '0;
			rem_q          <= '0;
			step_q         <= '0;
			mean_q         <= '0;
			result_valid_q <= 1'b0;
			result_q       <= '0;
		end else begin
			if (result_valid_q && result_ready && state_q != ST_FINISH) begin
				result_valid_q <= 1'b0;
			end

			unique case (state_q)
				ST_ACC: begin
					if (take) begin
						if (count_q < COUNT_FULL) begin
							if (count_q == '0) begin
								min_q <= item.sample;
								max_q <= item.sample;
							end else begin
								if (item.sample < min_q) begin
									min_q <= item.sample;
								end
								if (item.sample > max_q) begin
									max_q <= item.sample;
								end
							end
							sum_q   <= sum_q + smmv_pkg::SUM_W'(item.sample);
							sumsq_q <= sumsq_q + smmv_pkg::SQ_W'(prod);
							count_q <= count_q + 1'b1;
						end else begin
							ovf_q <= 1'b1;
						end
						if (item.last_item) begin
							state_q <= ST_MUL_SQ;
						end
					end
				end
				ST_MUL_SQ: begin
					sq_q    <= prod;
					state_q <= ST_MUL_LO;
				end
				ST_MUL_LO: begin
					acc_q   <= smmv_pkg::D_W'(prod);
					state_q <= ST_MUL_HI;
				end
				ST_MUL_HI: begin
					acc_q   <= acc_q + (smmv_pkg::D_W'(prod) << smmv_pkg::SQ_LO_W);
					state_q <= ST_MUL_N2;
				end
				ST_MUL_N2: begin
					// Form the variance numerator, keep n^2, and load the mean division.
					acc_q     <= diff;
					sq_q      <= prod;
					divisor_q <= smmv_pkg::DVS_W'(count_q);
					dvd_q     <= smmv_pkg::DVD_W'(sum_mag) << smmv_pkg::FRAC_BITS;
					rem_q     <= '0;
					step_q    <= '0;
					state_q   <= ST_DIV_MEAN;
				end
				ST_DIV_MEAN: begin
					rem_q  <= rem_nx;
					dvd_q  <= dvd_nx;
					step_q <= step_q + 1'b1;
					if (step_q == STEP_LAST) begin
						state_q <= ST_MEAN_END;
					end
				end
				ST_MEAN_END: begin
					// Capture the mean and start the variance division.
					mean_q    <= mean_nx;
					divisor_q <= smmv_pkg::DVS_W'(sq_q);
					dvd_q     <= smmv_pkg::DVD_W'(acc_q) << smmv_pkg::FRAC_BITS;
					rem_q     <= '0;
					step_q    <= '0;
					state_q   <= ST_DIV_VAR;
				end
				ST_DIV_VAR: begin
					rem_q  <= rem_nx;
					dvd_q  <= dvd_nx;
					step_q <= step_q + 1'b1;
					if (step_q == STEP_LAST) begin
						state_q <= ST_FINISH;
					end
				end
				ST_FINISH: begin
					if (out_free) begin
						result_q.max_value      <= max_q;
						result_q.min_value      <= min_q;
						result_q.mean_fixed     <= mean_q;
						result_q.variance_fixed <= var_nx;
						result_q.set_size       <= smmv_pkg::SET_SIZE_W'(count_q);
						result_q.too_many       <= ovf_q;
						result_valid_q          <= 1'b1;
						count_q                 <= '0;
						sum_q                   <= '0;
						sumsq_q                 <= '0;
						min_q                   <= '0;
						max_q                   <= '0;
						ovf_q                   <= 1'b0;
						state_q                 <= ST_ACC;
					end
				end
				default: begin
					state_q <= ST_ACC;
				end
			endcase
		end
	end

	// The count never passes the set capacity.
	`SMMV_NEVER(a_count_cap, clk, arst_n, count_q > COUNT_FULL, "sample count above capacity")

	// Minimum never exceeds maximum once a sample is counted.
	`SMMV_ASSERT(a_min_le_max, clk, arst_n, (count_q != '0) |-> (min_q <= max_q), "min above max")

	// Accepting the last sample stops intake for the closing computation.
	`SMMV_ASSERT(a_last_stalls, clk, arst_n, (take && item.last_item) |=> !item_ready, "intake open after last sample")

	// Publishing a result leaves an empty set behind.
	`SMMV_ASSERT(a_clear_after, clk, arst_n, (state_q == ST_FINISH && out_free) |=> (count_q == '0 && !ovf_q && result_valid_q), "set not cleared after result")

endmodule

`default_nettype wire
